/* src/obl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants of the order book price level unit
// Sizes, message and status codes, sequencer states, controller bundles.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int ORDER_SLOTS  = 65536;   // power of two
  localparam int PRICE_LEVELS = 1024;    // power of two, at least 16

  localparam int ID_W   = $clog2(ORDER_SLOTS);
  localparam int CNT_W  = ID_W + 1;
  localparam int LVL_W  = $clog2(PRICE_LEVELS);
  // occupancy bitmap is split in groups of words for a two step search
  localparam int NGRP   = (PRICE_LEVELS >= 64) ? PRICE_LEVELS / 32 : 2;
  localparam int GRP_SZ = PRICE_LEVELS / NGRP;
  localparam int GIW    = $clog2(NGRP);
  localparam int BIW    = $clog2(GRP_SZ);
  localparam int ENC_W  = (NGRP > GRP_SZ) ? NGRP : GRP_SZ;
  localparam int ENC_IW = $clog2(ENC_W);
  localparam int CLR_N  = (ORDER_SLOTS > 2 * PRICE_LEVELS) ? ORDER_SLOTS : 2 * PRICE_LEVELS;
  localparam int CLR_W  = $clog2(CLR_N);

  typedef enum logic [1:0] {OP_NEW, OP_DEL, OP_MOD, OP_TRADE} op_e;

  typedef enum logic [2:0] {
    ST_OK, ST_DUP, ST_PRICE, ST_ZERO, ST_NOTFOUND, ST_EXCEEDS, ST_WINDOW
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ORD, S_EVAL, S_L1RD, S_L1WR, S_L2RD, S_L2WR,
    S_GRP, S_IDX, S_BRD, S_ARD, S_RES
  } state_e;

  typedef enum logic [1:0] {LV_OP1, LV_OP2, LV_BID, LV_ASK} lvl_sel_e;

  typedef struct packed {
    logic        vld;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } ord_t;

  typedef struct packed {
    logic             en;
    logic             add;
    logic             side;
    logic [LVL_W-1:0] idx;
    logic [31:0]      amt;
  } lvl_op_t;

  typedef struct packed {
    logic     clr;
    logic     cap_in;
    logic     eval;
    lvl_sel_e lvl_sel;
    logic     lvl_wr;
    logic     best_grp;
    logic     best_idx;
    logic     bid_cap;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } sts_t;

  // index of the highest set bit
  function automatic logic [ENC_IW-1:0] enc_hi(logic [ENC_W-1:0] v);
    logic [ENC_IW-1:0] r;
    r = '0;
    for (int i = 0; i < ENC_W; i++) begin
      if (v[i]) r = ENC_IW'(i);
    end
    return r;
  endfunction

  // index of the lowest set bit
  function automatic logic [ENC_IW-1:0] enc_lo(logic [ENC_W-1:0] v);
    logic [ENC_IW-1:0] r;
    r = '0;
    for (int i = ENC_W - 1; i >= 0; i--) begin
      if (v[i]) r = ENC_IW'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/obl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_ctrl: sequencer of the order book price level unit
// Steps each transaction through lookup, level updates, best search, result.
// ----------------------------------------------------------------------------
module obl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire obl_pkg::sts_t sts_i,
  output obl_pkg::cmd_t      cmd_o
);
  import obl_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.cap_in = in_valid_i;
        if (in_valid_i) state_d = S_ORD;
      end
      S_ORD:  state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_L1RD;
      end
      S_L1RD: begin
        cmd_o.lvl_sel = LV_OP1;
        state_d       = S_L1WR;
      end
      S_L1WR: begin
        cmd_o.lvl_sel = LV_OP1;
        cmd_o.lvl_wr  = 1'b1;
        state_d       = S_L2RD;
      end
      S_L2RD: begin
        cmd_o.lvl_sel = LV_OP2;
        state_d       = S_L2WR;
      end
      S_L2WR: begin
        cmd_o.lvl_sel = LV_OP2;
        cmd_o.lvl_wr  = 1'b1;
        state_d       = S_GRP;
      end
      S_GRP: begin
        cmd_o.best_grp = 1'b1;
        state_d        = S_IDX;
      end
      S_IDX: begin
        cmd_o.best_idx = 1'b1;
        state_d        = S_BRD;
      end
      S_BRD: begin
        cmd_o.lvl_sel = LV_BID;
        state_d       = S_ARD;
      end
      S_ARD: begin
        cmd_o.lvl_sel = LV_ASK;
        cmd_o.bid_cap = 1'b1;
        state_d       = S_RES;
      end
      S_RES: begin
        // keep the ask level addressed so its read data holds while stalled
        cmd_o.lvl_sel = LV_ASK;
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

/* src/obl_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_dp: datapath of the order book price level unit
// Order table, level sums, occupancy bitmap, best search and result registers.
// ----------------------------------------------------------------------------
module obl_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire obl_pkg::cmd_t        cmd_i,
  output obl_pkg::sts_t             sts_o,
  input  wire logic                 cfg_valid_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic [1:0]           op_i,
  input  wire logic [15:0]          oid_i,
  input  wire logic                 side_i,
  input  wire logic signed [31:0]   price_i,
  input  wire logic [31:0]          quantity_i,
  output logic [2:0]                status_o,
  output logic signed [31:0]        best_bid_price_o,
  output logic [31:0]               best_bid_qty_o,
  output logic signed [31:0]        best_ask_price_o,
  output logic [31:0]               best_ask_qty_o,
  output logic                      crossed_o,
  output logic [obl_pkg::CNT_W-1:0] live_orders_o
);
  import obl_pkg::*;

  logic [31:0]      base_q;
  op_e              op_q;
  logic [ID_W-1:0]  id_q;
  logic             side_q;
  logic [31:0]      price_q, qty_q;

  ord_t             ord_mem [ORDER_SLOTS];
  ord_t             ord_rd_q;
  logic             ord_we;
  logic [ID_W-1:0]  ord_wa;
  ord_t             ord_wd, ord_new;

  logic [31:0]      lvl_mem [2*PRICE_LEVELS];
  logic [31:0]      lvl_rd_q;
  logic [LVL_W:0]   lvl_ra, lvl_wa;
  logic             lvl_we;
  logic [31:0]      lvl_wd, lvl_res;
  logic [32:0]      lvl_sum;
  lvl_op_t          op1_q, op2_q, op1_d, op2_d, cur_op;

  logic [1:0][NGRP-1:0][GRP_SZ-1:0] bmap_q;
  logic [CLR_W-1:0] clr_q;
  logic [CNT_W-1:0] cnt_q;
  status_e          st_q, st_d;
  logic             inc_d, dec_d;

  logic [GIW-1:0]   bgrp_q, agrp_q;
  logic             bany_q, aany_q;
  logic [LVL_W-1:0] bidx_q, aidx_q;
  logic [31:0]      bqty_q;
  logic [NGRP-1:0]  bgrp_or, agrp_or;

  // window checks
  logic [32:0] in_d, old_d, mdiff;
  logic        in_win, old_win, price_pos, qty_gt;
  logic [31:0] tr_left;

  assign sts_o.clr_done = (clr_q == CLR_W'(CLR_N - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd1;
      clr_q  <= '0;
      cnt_q  <= '0;
      bmap_q <= '0;
      op1_q  <= '0;
      op2_q  <= '0;
    end else begin
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.eval) begin
        op1_q <= op1_d;
        op2_q <= op2_d;
        if (inc_d) cnt_q <= cnt_q + 1'b1;
        else if (dec_d) cnt_q <= cnt_q - 1'b1;
      end
      if (lvl_we && !cmd_i.clr) bmap_q[lvl_wa[LVL_W]][lvl_wa[LVL_W-1:BIW]][lvl_wa[BIW-1:0]]
          <= (lvl_res != '0);
    end
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q    <= op_e'(op_i);
      id_q    <= ID_W'(oid_i);
      side_q  <= side_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
    end
  end

  // order table
  assign ord_we = cmd_i.clr ? (clr_q < CLR_W'(ORDER_SLOTS - 1) || clr_q == CLR_W'(ORDER_SLOTS - 1))
                            : (cmd_i.eval && st_d == ST_OK);
  assign ord_wa = cmd_i.clr ? ID_W'(clr_q) : id_q;
  assign ord_wd = cmd_i.clr ? ord_t'('0) : ord_new;

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_q <= ord_mem[id_q];
  end

  always_comb begin
    in_d      = {price_q[31], price_q} - {base_q[31], base_q};
    old_d     = {ord_rd_q.price[31], ord_rd_q.price} - {base_q[31], base_q};
    in_win    = (in_d[32:LVL_W] == '0);
    old_win   = (old_d[32:LVL_W] == '0);
    price_pos = !price_q[31] && (price_q != '0);
    mdiff     = {1'b0, qty_q} - {1'b0, ord_rd_q.qty};
    qty_gt    = (qty_q > ord_rd_q.qty);
    tr_left   = ord_rd_q.qty - qty_q;
  end

  // message evaluation
  always_comb begin
    st_d    = ST_OK;
    inc_d   = 1'b0;
    dec_d   = 1'b0;
    op1_d   = '0;
    op2_d   = '0;
    ord_new = ord_rd_q;
    unique case (op_q)
      OP_NEW: begin
        if (ord_rd_q.vld)        st_d = ST_DUP;
        else if (!price_pos)     st_d = ST_PRICE;
        else if (qty_q == '0)    st_d = ST_ZERO;
        else if (!in_win)        st_d = ST_WINDOW;
        else begin
          ord_new = '{vld: 1'b1, side: side_q, price: price_q, qty: qty_q};
          inc_d   = 1'b1;
          op2_d   = '{en: 1'b1, add: 1'b1, side: side_q, idx: in_d[LVL_W-1:0], amt: qty_q};
        end
      end
      OP_DEL: begin
        if (!ord_rd_q.vld) st_d = ST_NOTFOUND;
        else begin
          ord_new.vld = 1'b0;
          dec_d       = 1'b1;
          op1_d = '{en: old_win, add: 1'b0, side: ord_rd_q.side,
                    idx: old_d[LVL_W-1:0], amt: ord_rd_q.qty};
        end
      end
      OP_MOD: begin
        if (!ord_rd_q.vld)       st_d = ST_NOTFOUND;
        else if (qty_q == '0)    st_d = ST_ZERO;
        else if (!price_pos)     st_d = ST_PRICE;
        else if (!in_win)        st_d = ST_WINDOW;
        else begin
          ord_new = '{vld: 1'b1, side: side_q, price: price_q, qty: qty_q};
          if (ord_rd_q.price != price_q || ord_rd_q.side != side_q) begin
            // move: leave old level, join new one
            op1_d = '{en: old_win, add: 1'b0, side: ord_rd_q.side,
                      idx: old_d[LVL_W-1:0], amt: ord_rd_q.qty};
            op2_d = '{en: 1'b1, add: 1'b1, side: side_q, idx: in_d[LVL_W-1:0], amt: qty_q};
          end else if (qty_gt) begin
            op1_d = '{en: 1'b1, add: 1'b1, side: side_q, idx: in_d[LVL_W-1:0],
                      amt: mdiff[31:0]};
          end else begin
            op1_d = '{en: 1'b1, add: 1'b0, side: side_q, idx: in_d[LVL_W-1:0],
                      amt: 32'(-mdiff)};
          end
        end
      end
      OP_TRADE: begin
        if (!ord_rd_q.vld) st_d = ST_NOTFOUND;
        else if (qty_gt)   st_d = ST_EXCEEDS;
        else begin
          ord_new.qty = tr_left;
          if (tr_left == '0) begin
            ord_new.vld = 1'b0;
            dec_d       = 1'b1;
          end
          op1_d = '{en: old_win, add: 1'b0, side: ord_rd_q.side,
                    idx: old_d[LVL_W-1:0], amt: qty_q};
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) st_q <= st_d;
  end

  // level sums: one read, one read-modify-write per op
  assign cur_op = (cmd_i.lvl_sel == LV_OP2) ? op2_q : op1_q;

  always_comb begin
    unique case (cmd_i.lvl_sel)
      LV_OP1:  lvl_ra = {op1_q.side, op1_q.idx};
      LV_OP2:  lvl_ra = {op2_q.side, op2_q.idx};
      LV_BID:  lvl_ra = {1'b0, bidx_q};
      LV_ASK:  lvl_ra = {1'b1, aidx_q};
      default: lvl_ra = '0;
    endcase
    lvl_sum = {1'b0, lvl_rd_q} + {1'b0, cur_op.amt};
    if (cur_op.add) lvl_res = lvl_sum[32] ? '1 : lvl_sum[31:0];
    else            lvl_res = (lvl_rd_q <= cur_op.amt) ? '0 : lvl_rd_q - cur_op.amt;
    if (cmd_i.clr) begin
      lvl_we = (clr_q < CLR_W'(2 * PRICE_LEVELS - 1)) || (clr_q == CLR_W'(2 * PRICE_LEVELS - 1));
      lvl_wa = (LVL_W + 1)'(clr_q);
      lvl_wd = '0;
    end else begin
      lvl_we = cmd_i.lvl_wr && cur_op.en;
      lvl_wa = {cur_op.side, cur_op.idx};
      lvl_wd = lvl_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_rd_q <= lvl_mem[lvl_ra];
  end

  // best level search: group first, then bit within group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      bgrp_or[g] = |bmap_q[0][g];
      agrp_or[g] = |bmap_q[1][g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_grp) begin
      bany_q <= |bgrp_or;
      aany_q <= |agrp_or;
      bgrp_q <= GIW'(enc_hi(ENC_W'(bgrp_or)));
      agrp_q <= GIW'(enc_lo(ENC_W'(agrp_or)));
    end
    if (cmd_i.best_idx) begin
      bidx_q <= {bgrp_q, BIW'(enc_hi(ENC_W'(bmap_q[0][bgrp_q])))};
      aidx_q <= {agrp_q, BIW'(enc_lo(ENC_W'(bmap_q[1][agrp_q])))};
    end
    if (cmd_i.bid_cap) bqty_q <= lvl_rd_q;
    if (cmd_i.load_out) begin
      status_o         <= st_q;
      best_bid_price_o <= bany_q ? base_q + 32'(bidx_q) : '0;
      best_bid_qty_o   <= bany_q ? bqty_q : '0;
      best_ask_price_o <= aany_q ? base_q + 32'(aidx_q) : '0;
      best_ask_qty_o   <= aany_q ? lvl_rd_q : '0;
      crossed_o        <= bany_q && aany_q && (bidx_q >= aidx_q);
      live_orders_o    <= cnt_q;
    end
  end

endmodule
`default_nettype wire

/* src/order_book_price_levels_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_price_levels_unit: limit order book with price level sums
// Transactions: one at a time; in_ready drops once a message is taken and
//   returns after its result loads; the walk is set by the level memory
//   (two read-modify-writes plus two best-quantity reads) and the
//   two step bitmap search.
// Reset: clearing pass over the order table and level sums; no input is
//   taken meanwhile, config writes still are.
// ----------------------------------------------------------------------------
module order_book_price_levels_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration: price_base
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [31:0]          cfg_data_i,
  // message transaction
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [15:0]          oid_i,
  input  wire logic                 side_i,
  input  wire logic signed [31:0]   price_i,
  input  wire logic [31:0]          quantity_i,
  // result transaction
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic signed [31:0]        best_bid_price_o,
  output logic [31:0]               best_bid_qty_o,
  output logic signed [31:0]        best_ask_price_o,
  output logic [31:0]               best_ask_qty_o,
  output logic                      crossed_o,
  output logic [obl_pkg::CNT_W-1:0] live_orders_o
);
  import obl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes land at once; user writes only while idle (not enforced)
  assign cfg_ready_o = 1'b1;

  // sequencer: clearing pass, then a fixed walk per transaction; the result
  // register lets the next message in while a result still waits
  obl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // order table memory, level sum memory (bid then ask half), occupancy
  // bitmap in flops for the best search
  obl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .oid_i            (oid_i),
    .side_i           (side_i),
    .price_i          (price_i),
    .quantity_i       (quantity_i),
    .status_o         (status_o),
    .best_bid_price_o (best_bid_price_o),
    .best_bid_qty_o   (best_bid_qty_o),
    .best_ask_price_o (best_ask_price_o),
    .best_ask_qty_o   (best_ask_qty_o),
    .crossed_o        (crossed_o),
    .live_orders_o    (live_orders_o)
  );

endmodule
`default_nettype wire

/* src/obl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_checker: port level checks of the order book price level unit
// Bound to the top level.
// ----------------------------------------------------------------------------
module obl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        crossed_o,
  input wire logic [31:0] best_bid_qty_o,
  input wire logic [31:0] best_ask_qty_o,
  input wire logic [31:0] best_bid_price_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  a_crossed_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crossed_o |-> best_bid_qty_o != 0 && best_ask_qty_o != 0)
    else $error("crossed with an empty side");

  a_empty_bid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && best_bid_qty_o == 0 |-> best_bid_price_o == 0)
    else $error("bid price without quantity");

endmodule

bind order_book_price_levels_unit obl_checker u_obl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .crossed_o        (crossed_o),
  .best_bid_qty_o   (best_bid_qty_o),
  .best_ask_qty_o   (best_ask_qty_o),
  .best_bid_price_o (best_bid_price_o)
);
`default_nettype wire
